// ===== rtl/btc_pkg.sv =====
// Shared types and helpers for the barometric compensation pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package btc_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CoefW  = 48;
  localparam int unsigned RawW   = 20;
  localparam int unsigned DivLen = 32;

  typedef enum logic [1:0] {
    REG_TEMP    = 2'd0,
    REG_PRESS_A = 2'd1,
    REG_PRESS_B = 2'd2,
    REG_PRESS_C = 2'd3
  } reg_idx_e;

  // values carried alongside the pressure path
  typedef struct packed {
    logic [DataW-1:0] temp;
    logic [DataW-1:0] fine;
    logic             invalid;
    logic             mode;     // dividend was not pre-doubled
  } side_t;

  typedef struct packed {
    logic [RawW-1:0]  adc_p;
    logic [DataW-1:0] temp;
    logic [DataW-1:0] fine;
  } temp_res_t;

  typedef struct packed {
    logic [DataW-1:0] rem;
    logic [DataW-1:0] num;
    logic [DataW-1:0] den;
    logic [DataW-1:0] quo;
    side_t            side;
  } div_st_t;

  typedef struct packed {
    logic [DataW-1:0] quo;
    side_t            side;
  } div_res_t;

  function automatic logic [DataW-1:0] sx16(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic logic [DataW-1:0] word_s(input logic [CoefW-1:0] r, input int unsigned k);
    return sx16(r[16*k +: 16]);
  endfunction

  function automatic logic [DataW-1:0] asr(input logic [DataW-1:0] x, input int unsigned n);
    return DataW'($signed(x) >>> n);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/btc_temp.sv =====
// Temperature compensation stages: raw temperature to fine value and 0.01 degC.
// Depends on btc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module btc_temp (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic [19:0]             raw_temp_i,
  input  wire logic [19:0]             raw_press_i,
  input  wire logic [47:0]             temp_coefs_i,
  output logic                         valid_o,
  output btc_pkg::temp_res_t           res_o
);
  import btc_pkg::*;

  logic [4:0]       vld_q;
  logic [DataW-1:0] x1_q, d_q, m1_q, dd_q, at_q, b0_q, fine_q;
  logic [RawW-1:0]  ap1_q, ap2_q, ap3_q, ap4_q;
  logic [DataW-1:0] t1, t2, t3, fine_d, temp_d;

  assign t1 = {16'd0, temp_coefs_i[15:0]};
  assign t2 = word_s(temp_coefs_i, 1);
  assign t3 = word_s(temp_coefs_i, 2);

  assign fine_d = at_q + asr(b0_q, 14);
  assign temp_d = asr(fine_q * 32'd5 + 32'd128, 8);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q   <= {15'd0, raw_temp_i[19:3]} - {t1[30:0], 1'b0};
      d_q    <= {16'd0, raw_temp_i[19:4]} - t1;
      ap1_q  <= raw_press_i;
      m1_q   <= x1_q * t2;
      dd_q   <= d_q * d_q;
      ap2_q  <= ap1_q;
      at_q   <= asr(m1_q, 11);
      b0_q   <= asr(dd_q, 12) * t3;
      ap3_q  <= ap2_q;
      fine_q <= fine_d;
      ap4_q  <= ap3_q;
      res_o.temp  <= temp_d;
      res_o.fine  <= fine_q;
      res_o.adc_p <= ap4_q;
    end
  end

  assign valid_o = vld_q[4];
endmodule
`default_nettype wire

// ===== rtl/btc_press.sv =====
// Pressure stages ahead of the divider: offset, scale and dividend setup.
// Depends on btc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module btc_press (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire btc_pkg::temp_res_t      res_i,
  input  wire logic [47:0]             press_a_i,
  input  wire logic [47:0]             press_b_i,
  output logic                         valid_o,
  output btc_pkg::div_st_t             div_o
);
  import btc_pkg::*;

  logic [6:0]       vld_q;
  logic [DataW-1:0] p1, p2, p3, p4, p5, p6;
  temp_res_t        t6_q, t7_q, t8_q, t9_q, t10_q, t11_q;
  logic [DataW-1:0] ap_d, q_d, sq_q, m5_q, m2_q;
  logic [DataW-1:0] b1_q, m5b_q, m2b_q, m3_q;
  logic [DataW-1:0] b_q, a2_q, b9_q, a3_q, a_q, pp_q, a11_q, p_q;

  assign p1 = {16'd0, press_a_i[15:0]};
  assign p2 = word_s(press_a_i, 1);
  assign p3 = word_s(press_a_i, 2);
  assign p4 = word_s(press_b_i, 0);
  assign p5 = word_s(press_b_i, 1);
  assign p6 = word_s(press_b_i, 2);

  assign ap_d = asr(res_i.fine, 1) - 32'd64000;
  assign q_d  = asr(ap_d, 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // squares and first products of the offset term
      sq_q  <= q_d * q_d;
      m5_q  <= ap_d * p5;
      m2_q  <= p2 * ap_d;
      t6_q  <= res_i;
      b1_q  <= asr(sq_q, 11) * p6;
      m3_q  <= p3 * asr(sq_q, 13);
      m5b_q <= m5_q;
      m2b_q <= m2_q;
      t7_q  <= t6_q;
      b_q   <= asr(b1_q + {m5b_q[30:0], 1'b0}, 2) + {p4[15:0], 16'd0};
      a2_q  <= asr(asr(m3_q, 3) + asr(m2b_q, 1), 18);
      t8_q  <= t7_q;
      a3_q  <= (32'd32768 + a2_q) * p1;
      b9_q  <= b_q;
      t9_q  <= t8_q;
      a_q   <= asr(a3_q, 15);
      pp_q  <= (32'd1048576 - {12'd0, t9_q.adc_p}) - asr(b9_q, 12);
      t10_q <= t9_q;
      p_q   <= pp_q * 32'd3125;
      a11_q <= a_q;
      t11_q <= t10_q;
      div_o.rem          <= '0;
      div_o.quo          <= '0;
      div_o.den          <= a11_q;
      div_o.num          <= p_q[31] ? p_q : {p_q[30:0], 1'b0};
      div_o.side.mode    <= p_q[31];
      div_o.side.invalid <= (a11_q == '0);
      div_o.side.temp    <= t11_q.temp;
      div_o.side.fine    <= t11_q.fine;
    end
  end

  assign valid_o = vld_q[6];
endmodule
`default_nettype wire

// ===== rtl/btc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned 32/32.
// Depends on btc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module btc_div (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire btc_pkg::div_st_t        div_i,
  output logic                         valid_o,
  output btc_pkg::div_res_t            res_o
);
  import btc_pkg::*;

  div_st_t          st_q [DivLen];
  logic [DivLen-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DivLen-2:0], valid_i};
    end
  end

  for (genvar g = 0; g < DivLen; g++) begin : g_stage
    div_st_t         src, nxt;
    logic [DataW:0]  sh, diff;
    assign src  = (g == 0) ? div_i : st_q[(g == 0) ? 0 : g-1];
    assign sh   = {src.rem, src.num[DataW-1]};
    assign diff = sh - {1'b0, src.den};
    always_comb begin
      nxt     = src;
      nxt.num = {src.num[DataW-2:0], 1'b0};
      nxt.rem = diff[DataW] ? sh[DataW-1:0] : diff[DataW-1:0];
      nxt.quo = {src.quo[DataW-2:0], ~diff[DataW]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g] <= nxt;
      end
    end
  end

  assign valid_o    = vld_q[DivLen-1];
  assign res_o.quo  = st_q[DivLen-1].quo;
  assign res_o.side = st_q[DivLen-1].side;
endmodule
`default_nettype wire

// ===== rtl/btc_post.sv =====
// Final pressure correction with P7..P9; holds the output register.
// Depends on btc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module btc_post (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire btc_pkg::div_res_t       res_i,
  input  wire logic [47:0]             press_c_i,
  output logic                         valid_o,
  output logic [31:0]                  temp_o,
  output logic [31:0]                  fine_o,
  output logic [31:0]                  press_o,
  output logic                         invalid_o
);
  import btc_pkg::*;

  logic [3:0]       vld_q;
  side_t            s1_q, s2_q, s3_q;
  logic [DataW-1:0] p7, p8, p9, qq;
  logic [DataW-1:0] p1_q, p2_q, p3_q, sq_q, v2_q, v2b_q, v1_q, corr;

  assign p7 = word_s(press_c_i, 0);
  assign p8 = word_s(press_c_i, 1);
  assign p9 = word_s(press_c_i, 2);
  assign qq = {3'd0, p1_q[31:3]};
  assign corr = asr(asr(v1_q, 12) + asr(v2b_q, 13) + p7, 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q  <= res_i.side.mode ? {res_i.quo[30:0], 1'b0} : res_i.quo;
      s1_q  <= res_i.side;
      sq_q  <= qq * qq;
      v2_q  <= {2'd0, p1_q[31:2]} * p8;
      p2_q  <= p1_q;
      s2_q  <= s1_q;
      v1_q  <= p9 * {13'd0, sq_q[31:13]};
      v2b_q <= v2_q;
      p3_q  <= p2_q;
      s3_q  <= s2_q;
      temp_o    <= s3_q.temp;
      fine_o    <= s3_q.fine;
      invalid_o <= s3_q.invalid;
      press_o   <= s3_q.invalid ? '0 : p3_q + corr;
    end
  end

  assign valid_o = vld_q[3];
endmodule
`default_nettype wire

// ===== rtl/baro_temp_press_compensation.sv =====
// Barometric compensation, 32-bit integer scheme. One request per cycle
// sustained, set by a fully pipelined datapath with a 32-stage
// one-bit-per-stage divider.
// The whole pipeline stalls only while the output holds an untaken result.
// Reset (async, active low) clears valid bits and calibration registers.
// Depends on btc_pkg, btc_temp, btc_press, btc_div, btc_post.
`timescale 1ns / 1ps
`default_nettype none
module baro_temp_press_compensation (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // raw_temp[19:0], raw_press[39:20]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,   // temp_centideg, fine_temp, press_pa
  output logic [0:0]       m_axis_tuser,   // press_invalid
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [47:0] cfg_data_i
);
  import btc_pkg::*;

  logic [CoefW-1:0] tc_q, pa_q, pb_q, pc_q;
  logic             en, t_vld, p_vld, d_vld;
  temp_res_t        t_res;
  div_st_t          d_in;
  div_res_t         d_res;
  logic [31:0]      temp, fine, press;
  logic             inval;

  assign cfg_ready_o   = 1'b1;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0;
      pa_q <= '0;
      pb_q <= '0;
      pc_q <= '0;
    end else if (cfg_valid_i && cfg_index_i[7:2] == '0) begin
      unique case (reg_idx_e'(cfg_index_i[1:0]))
        REG_TEMP:    tc_q <= cfg_data_i;
        REG_PRESS_A: pa_q <= cfg_data_i;
        REG_PRESS_B: pb_q <= cfg_data_i;
        REG_PRESS_C: pc_q <= cfg_data_i;
        default:     tc_q <= tc_q;
      endcase
    end
  end

  btc_temp u_temp (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid && en),
    .raw_temp_i(s_axis_tdata[19:0]), .raw_press_i(s_axis_tdata[39:20]),
    .temp_coefs_i(tc_q), .valid_o(t_vld), .res_o(t_res)
  );

  btc_press u_press (
    .clk_i, .rst_ni, .en_i(en), .valid_i(t_vld), .res_i(t_res),
    .press_a_i(pa_q), .press_b_i(pb_q), .valid_o(p_vld), .div_o(d_in)
  );

  btc_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p_vld), .div_i(d_in),
    .valid_o(d_vld), .res_o(d_res)
  );

  btc_post u_post (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_vld), .res_i(d_res),
    .press_c_i(pc_q), .valid_o(m_axis_tvalid), .temp_o(temp), .fine_o(fine),
    .press_o(press), .invalid_o(inval)
  );

  assign m_axis_tdata = {press, fine, temp};
  assign m_axis_tuser = inval;
endmodule
`default_nettype wire

// ===== rtl/btc_checker.sv =====
// Port-level checks for the compensation block, bound to the top level.
// Depends on baro_temp_press_compensation ports only.
`timescale 1ns / 1ps
`default_nettype none
module btc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [95:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_inval_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[95:64] == 32'd0)
    else $error("invalid pressure not zero");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result dropped without request");
endmodule

bind baro_temp_press_compensation btc_checker u_btc_checker (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser
);
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for baro_temp_press_compensation: directed table then random samples,
// checked against an in-bench integer compensation predictor. Depends on btc_pkg.
`timescale 1ns / 1ps
module tb_top;
  import btc_pkg::*;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic [31:0] press;
    logic        invalid;
  } comp_res_t;

  typedef struct {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
    bit          known;
    comp_res_t   res;
  } stim_row_t;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [95:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid_i, cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [47:0] cfg_data_i;

  baro_temp_press_compensation u_top (.*);

  logic [47:0] cal [4];
  comp_res_t   expected_q[$];
  int          mismatches = 0;
  bit          rx_idle_en = 1;
  bit          hold_off = 0;
  bit          tx_idle_en = 1;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [31:0] sra(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] cw_s(int r, int k);
    logic [15:0] w;
    w = cal[r][16*k +: 16];
    return {{16{w[15]}}, w};
  endfunction

  function automatic comp_res_t compensate(logic [19:0] raw_t, logic [19:0] raw_p);
    logic [31:0] at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, sq, fine, p, q, v1, v2;
    comp_res_t r;
    at = {12'd0, raw_t}; ap = {12'd0, raw_p};
    t1 = {16'd0, cal[REG_TEMP][15:0]}; t2 = cw_s(REG_TEMP, 1); t3 = cw_s(REG_TEMP, 2);
    p1 = {16'd0, cal[REG_PRESS_A][15:0]}; p2 = cw_s(REG_PRESS_A, 1);
    p3 = cw_s(REG_PRESS_A, 2);
    p4 = cw_s(REG_PRESS_B, 0); p5 = cw_s(REG_PRESS_B, 1); p6 = cw_s(REG_PRESS_B, 2);
    p7 = cw_s(REG_PRESS_C, 0); p8 = cw_s(REG_PRESS_C, 1); p9 = cw_s(REG_PRESS_C, 2);
    a = sra(((at >> 3) - (t1 << 1)) * t2, 11);
    d = (at >> 4) - t1;
    b = sra(sra(d * d, 12) * t3, 14);
    fine = a + b;
    r.temp = sra(fine * 32'd5 + 32'd128, 8);
    r.fine = fine;
    a = sra(fine, 1) - 32'd64000;
    sq = sra(a, 2) * sra(a, 2);
    b = sra(sq, 11) * p6;
    b = b + ((a * p5) << 1);
    b = sra(b, 2) + (p4 << 16);
    a = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * a, 1), 18);
    a = sra((32'd32768 + a) * p1, 15);
    r.invalid = (a == 0);
    p = 0;
    if (a != 0) begin
      p = ((32'd1048576 - ap) - sra(b, 12)) * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / a;
      else p = (p / a) * 32'd2;
      q = p >> 3;
      v1 = sra(p9 * ((q * q) >> 13), 12);
      v2 = sra((p >> 2) * p8, 13);
      p = p + sra(v1 + v2 + p7, 4);
    end
    r.press = p;
    return r;
  endfunction

  task automatic write_cal(logic [7:0] idx, logic [47:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx < 4) cal[idx[1:0]] = val;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // tvalid stays high after a request so that the next one can follow directly
  task automatic send_sample(logic [19:0] rt, logic [19:0] rp, bit known, comp_res_t kres);
    @(negedge clk_i);
    while (tx_idle_en && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1; s_axis_tdata <= {rp, rt};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(known ? kres : compensate(rt, rp));
  endtask

  task automatic drain;
    @(negedge clk_i);
    s_axis_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // typical factory calibration, used for well-formed random samples
  task automatic load_typical;
    write_cal(REG_TEMP,    {16'd50, 16'd26435, 16'd27504});
    write_cal(REG_PRESS_A, {16'hD0D0 /* -12080 */, 16'hD5D1, 16'd36477});
    write_cal(REG_PRESS_B, {16'hFFF9, 16'd140, 16'd2855});
    write_cal(REG_PRESS_C, {16'd6000, 16'hD7C8, 16'd15500});
  endtask

  // output side
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 0;
    else m_axis_tready <= !(rx_idle_en && $urandom_range(99) < 22);
  end

  always @(posedge clk_i) begin
    comp_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tuser[0]};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp t=%h f=%h p=%h i=%b got t=%h f=%h p=%h i=%b",
                     want.temp, want.fine, want.press, want.invalid,
                     got.temp, got.fine, got.press, got.invalid);
        end
      end
    end
  end

  stim_row_t dir_tab[$];

  initial begin
    stim_row_t row;
    comp_res_t zero_res;
    s_axis_tvalid = 0; s_axis_tdata = 0; m_axis_tready = 0;
    cfg_valid_i = 0; cfg_index_i = 0; cfg_data_i = 0;
    foreach (cal[i]) cal[i] = 0;
    rst_ni = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1;

    // all-zero calibration: fine is 0, divisor is zero so pressure flagged
    zero_res = '{temp: 32'd0, fine: 32'd0, press: 32'd0, invalid: 1'b1};
    dir_tab.push_back('{20'd0, 20'd0, 1, zero_res});
    dir_tab.push_back('{20'hFFFFF, 20'hFFFFF, 0, zero_res});
    dir_tab.push_back('{20'hFFFFF, 20'd0, 0, zero_res});
    dir_tab.push_back('{20'd0, 20'hFFFFF, 0, zero_res});
    foreach (dir_tab[i]) send_sample(dir_tab[i].raw_t, dir_tab[i].raw_p, dir_tab[i].known,
                                     dir_tab[i].res);
    drain();
    load_typical();
    write_cal(8'd7, 48'hFFFF_FFFF_FFFF); // unknown index, ignored
    dir_tab.delete();
    dir_tab.push_back('{20'd519888, 20'd415148, 0, zero_res});
    dir_tab.push_back('{20'd0, 20'd0, 0, zero_res});
    dir_tab.push_back('{20'hFFFFF, 20'hFFFFF, 0, zero_res});
    dir_tab.push_back('{20'h80000, 20'h7FFFF, 0, zero_res});
    foreach (dir_tab[i]) send_sample(dir_tab[i].raw_t, dir_tab[i].raw_p, 0, zero_res);
    drain();
    // extremes of every register
    for (int i = 0; i < 4; i++) write_cal(i[7:0], 48'hFFFF_FFFF_FFFF);
    for (int i = 0; i < 4; i++) send_sample(20'($urandom), 20'($urandom), 0, zero_res);
    send_sample(20'hFFFFF, 20'd0, 0, zero_res);
    drain();
    for (int i = 0; i < 4; i++) write_cal(i[7:0], 48'h8000_8000_8000);
    send_sample(20'd0, 20'hFFFFF, 0, zero_res);
    send_sample(20'hFFFFF, 20'hFFFFF, 0, zero_res);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 3 == 2) for (int i = 0; i < 4; i++) write_cal(i[7:0], 48'({$urandom, $urandom}));
      else begin
        load_typical();
        if (ph == 1) write_cal(REG_PRESS_C, 48'({$urandom, $urandom}));
      end
      tx_idle_en = (ph != 3); rx_idle_en = (ph != 3);
      if (ph == 4) fork
        begin
          hold_off = 1;
          repeat (300) @(posedge clk_i);
          hold_off = 0;
        end
      join_none
      for (int n = 0; n < 200; n++) begin
        if (ph % 3 != 2 && $urandom_range(3) != 0)
          send_sample(20'($urandom_range(560000, 480000)), 20'($urandom_range(460000, 250000)),
                      0, zero_res);
        else send_sample(20'($urandom), 20'($urandom), 0, zero_res);
      end
      drain();
    end

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/btc_pkg.sv
rtl/btc_temp.sv
rtl/btc_press.sv
rtl/btc_div.sv
rtl/btc_post.sv
rtl/baro_temp_press_compensation.sv
rtl/btc_checker.sv
dv/tb_top.sv
